// File: design/grr_pkg.sv
// Shared types, widths, codes and defaults for the glyph row renderer.
// No dependencies; every other design file but grr_ram refers to this package by scope.
package grr_pkg;

  // Default values of the top level parameters
  localparam int MAX_GLYPH_ROWS_DEF = 16;
  localparam int MAX_ROW_BYTES_DEF  = 2;
  localparam int FONT_BYTES_DEF     = 8192;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int CODE_W     = 8;
  localparam int POS_W      = 12;
  localparam int FADDR_W    = 13;
  localparam int FBYTE_W    = 8;
  localparam int ROWY_W     = 13;
  localparam int BITS_W     = 16;
  localparam int CNT_W      = 5;
  localparam int COLOR_W    = 32;
  localparam int DIRTY_W    = 13;
  localparam int DIM_W      = 5;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
  localparam logic [1:0] REG_INK_COLOR    = 2'd2;
  localparam logic [1:0] REG_PAPER_COLOR  = 2'd3;

  // Register reset values
  localparam logic [DIM_W-1:0]   GLYPH_WIDTH_RST  = 5'd8;
  localparam logic [DIM_W-1:0]   GLYPH_HEIGHT_RST = 5'd8;
  localparam logic [COLOR_W-1:0] INK_COLOR_RST    = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] PAPER_COLOR_RST  = 32'h0000_0000;

  // A lone character with this code draws the underline cursor
  localparam logic [CODE_W-1:0] CURSOR_CODE = 8'd255;

  typedef struct packed {
    logic [DIM_W-1:0]   glyph_width;
    logic [DIM_W-1:0]   glyph_height;
    logic [COLOR_W-1:0] ink_color;
    logic [COLOR_W-1:0] paper_color;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic latch_load;
    logic latch_draw;
    logic clear_dirty;
    logic mul;
    logic red_step;
    logic ram_we;
    logic ram_re;
    logic acc;
    logic emit_row;
    logic emit_cursor;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             in_valid;
    logic [CMD_W-1:0] in_cmd;
    logic             in_cursor;
    logic             red_done;
    logic             byte_last;
    logic             row_last;
    logic             out_free;
  } ctrl_sts_t;

endpackage

// File: design/grr_cmd_if.sv
// Input channel of the glyph row renderer: valid/ready plus command payload.
// Depends on grr_pkg for field widths.
interface grr_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [grr_pkg::CMD_W-1:0]   command;
  logic [grr_pkg::CODE_W-1:0]  char_code;
  logic [grr_pkg::POS_W-1:0]   pos_x;
  logic [grr_pkg::POS_W-1:0]   pos_y;
  logic                        single_char;
  logic [grr_pkg::FADDR_W-1:0] font_addr;
  logic [grr_pkg::FBYTE_W-1:0] font_byte;

  modport source (
    output valid, command, char_code, pos_x, pos_y, single_char, font_addr, font_byte,
    input  ready
  );
  modport sink (
    input  valid, command, char_code, pos_x, pos_y, single_char, font_addr, font_byte,
    output ready
  );
endinterface

// File: design/grr_row_if.sv
// Output channel of the glyph row renderer: valid/ready plus one glyph row.
// Depends on grr_pkg for field widths.
interface grr_row_if;
  logic                        valid;
  logic                        ready;
  logic [grr_pkg::POS_W-1:0]   row_x;
  logic [grr_pkg::ROWY_W-1:0]  row_y;
  logic [grr_pkg::BITS_W-1:0]  pixel_bits;
  logic [grr_pkg::CNT_W-1:0]   pixel_count;
  logic [grr_pkg::COLOR_W-1:0] color_on;
  logic [grr_pkg::COLOR_W-1:0] color_off;
  logic [grr_pkg::DIRTY_W-1:0] dirty_first;
  logic [grr_pkg::DIRTY_W-1:0] dirty_past;
  logic                        last;

  modport source (
    output valid, row_x, row_y, pixel_bits, pixel_count, color_on, color_off,
           dirty_first, dirty_past, last,
    input  ready
  );
  modport sink (
    input  valid, row_x, row_y, pixel_bits, pixel_count, color_on, color_off,
           dirty_first, dirty_past, last,
    output ready
  );
endinterface

// File: design/glyph_row_renderer_unit.sv
// Glyph row renderer top level: config registers, sequencer and datapath.
// Depends on grr_pkg, grr_cmd_if, grr_row_if, grr_cfg, grr_ctrl, grr_dp.
//
// Takes one command item at a time. A font load reduces the address and writes
// one byte, a clear empties the dirty range, an unused command is dropped, a
// cursor emits one row, and a glyph draw forms the base address, reduces it and,
// for each of the H rows of the effective glyph height, reads the B = ceil(width / 8)
// bytes of the row and emits it. The address modulo reduction takes KS steps
// (KS = R - ceil(log2(FONT_BYTES)) + 1, R being the widest of 13, ceil(log2(FONT_BYTES))
// and 8 + bits(MAX_ROW_BYTES) + bits(MAX_GLYPH_ROWS); 3 with the defaults). The
// font memory has a single read port, one byte per read with registered data, and
// the address reducer takes one step per cycle. Each row leaves through an output
// register, so the next command is taken while the final row still waits.
// The font store has no reset; reading bytes never written gives undefined rows.
module glyph_row_renderer_unit #(
  parameter int MAX_GLYPH_ROWS = grr_pkg::MAX_GLYPH_ROWS_DEF,
  parameter int MAX_ROW_BYTES  = grr_pkg::MAX_ROW_BYTES_DEF,
  parameter int FONT_BYTES     = grr_pkg::FONT_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [grr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [grr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [grr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  grr_cmd_if.sink                        cmd_i,
  grr_row_if.source                      row_o
);

  grr_pkg::cfg_t      cfg;
  grr_pkg::ctrl_cmd_t ctrl_cmd;
  grr_pkg::ctrl_sts_t ctrl_sts;

  grr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  grr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (ctrl_sts),
    .cmd_o  (ctrl_cmd)
  );

  grr_dp #(
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .FONT_BYTES     (FONT_BYTES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (ctrl_cmd),
    .sts_o  (ctrl_sts),
    .in_ch  (cmd_i),
    .out_ch (row_o)
  );

endmodule

// File: design/grr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/grr_cfg.sv
// APB-style configuration registers: glyph size and the two colors.
// Depends on grr_pkg for register indexes, reset values and cfg_t.
module grr_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [grr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [grr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [grr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output grr_pkg::cfg_t                      cfg_o
);

  grr_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        grr_pkg::REG_GLYPH_WIDTH:  cfg_d.glyph_width  = pwdata[grr_pkg::DIM_W-1:0];
        grr_pkg::REG_GLYPH_HEIGHT: cfg_d.glyph_height = pwdata[grr_pkg::DIM_W-1:0];
        grr_pkg::REG_INK_COLOR:    cfg_d.ink_color    = pwdata;
        grr_pkg::REG_PAPER_COLOR:  cfg_d.paper_color  = pwdata;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width  <= grr_pkg::GLYPH_WIDTH_RST;
      cfg_q.glyph_height <= grr_pkg::GLYPH_HEIGHT_RST;
      cfg_q.ink_color    <= grr_pkg::INK_COLOR_RST;
      cfg_q.paper_color  <= grr_pkg::PAPER_COLOR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      grr_pkg::REG_GLYPH_WIDTH:  prdata = grr_pkg::APB_DATA_W'(cfg_q.glyph_width);
      grr_pkg::REG_GLYPH_HEIGHT: prdata = grr_pkg::APB_DATA_W'(cfg_q.glyph_height);
      grr_pkg::REG_INK_COLOR:    prdata = cfg_q.ink_color;
      grr_pkg::REG_PAPER_COLOR:  prdata = cfg_q.paper_color;
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/grr_ctrl.sv
// Sequencer of the glyph row renderer: steps loads, draws and cursors.
// Depends on grr_pkg for command codes and the command/status structs.
module grr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grr_pkg::ctrl_sts_t  sts_i,
  output grr_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_RED    = 8'b0000_0100,
    S_WRITE  = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_ACC    = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_CURSOR = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   is_load_q, is_load_d;

  // Next state and command decode
  always_comb begin
    state_d   = state_q;
    is_load_d = is_load_q;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          unique case (sts_i.in_cmd)
            grr_pkg::CMD_LOAD: begin
              cmd_o.latch_load = 1'b1;
              is_load_d        = 1'b1;
              state_d          = S_RED;
            end
            grr_pkg::CMD_DRAW: begin
              cmd_o.latch_draw = 1'b1;
              is_load_d        = 1'b0;
              state_d          = sts_i.in_cursor ? S_CURSOR : S_MUL;
            end
            grr_pkg::CMD_CLEAR: begin
              cmd_o.clear_dirty = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_RED;
      end
      S_RED: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.red_done) begin
          state_d = is_load_q ? S_WRITE : S_READ;
        end
      end
      S_WRITE: begin
        cmd_o.ram_we = 1'b1;
        state_d      = S_IDLE;
      end
      S_READ: begin
        cmd_o.ram_re = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.byte_last ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_row = 1'b1;
          state_d        = sts_i.row_last ? S_IDLE : S_READ;
        end
      end
      S_CURSOR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_cursor = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      is_load_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_load_q <= is_load_d;
    end
  end

endmodule

// File: design/grr_dp.sv
// Datapath: address reduction, font memory, row assembly, dirty range, output register.
// Depends on grr_pkg, grr_cmd_if, grr_row_if and grr_ram.
module grr_dp #(
  parameter int MAX_GLYPH_ROWS = grr_pkg::MAX_GLYPH_ROWS_DEF,
  parameter int MAX_ROW_BYTES  = grr_pkg::MAX_ROW_BYTES_DEF,
  parameter int FONT_BYTES     = grr_pkg::FONT_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grr_pkg::cfg_t      cfg_i,
  input  grr_pkg::ctrl_cmd_t cmd_i,
  output grr_pkg::ctrl_sts_t sts_o,
  grr_cmd_if.sink            in_ch,
  grr_row_if.source          out_ch
);

  localparam int AW    = $clog2(FONT_BYTES);
  localparam int NBW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int HW    = $clog2(MAX_GLYPH_ROWS + 1);
  localparam int WW    = $clog2(MAX_ROW_BYTES * 8 + 1);
  localparam int BCW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RCW   = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
  localparam int NHW   = NBW + HW;
  localparam int PW    = grr_pkg::CODE_W + NHW;
  localparam int RW0   = (PW > grr_pkg::FADDR_W) ? PW : grr_pkg::FADDR_W;
  localparam int RW    = (RW0 > AW) ? RW0 : AW;
  localparam int ACCW  = 8 * MAX_ROW_BYTES;
  localparam logic [RW:0]   SUB_INIT = (RW + 1)'(FONT_BYTES) << (RW - AW);
  localparam logic [RW:0]   SUB_LAST = (RW + 1)'(FONT_BYTES);
  localparam logic [RW-1:0] ADDR_TOP = RW'(FONT_BYTES - 1);
  localparam logic [5:0]    W_MAX    = 6'(MAX_ROW_BYTES * 8);
  localparam logic [5:0]    H_MAX    = 6'(MAX_GLYPH_ROWS);

  // Effective glyph size from configuration
  logic [5:0]     gw6, gh6, wsat6, hsat6, nb6;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [NBW-1:0] nb_eff;

  always_comb begin
    gw6 = 6'(cfg_i.glyph_width);
    gh6 = 6'(cfg_i.glyph_height);
    priority if (gw6 == 6'd0)  wsat6 = 6'd1;
    else if (gw6 > W_MAX)      wsat6 = W_MAX;
    else                       wsat6 = gw6;
    priority if (gh6 == 6'd0)  hsat6 = 6'd1;
    else if (gh6 > H_MAX)      hsat6 = H_MAX;
    else                       hsat6 = gh6;
    nb6    = (wsat6 + 6'd7) >> 3;
    w_eff  = WW'(wsat6);
    h_eff  = HW'(hsat6);
    nb_eff = NBW'(nb6);
  end

  // Latched draw parameters and font load byte
  logic [grr_pkg::CODE_W-1:0]  code_q;
  logic [grr_pkg::POS_W-1:0]   px_q, py_q;
  logic [WW-1:0]               w_q;
  logic [HW-1:0]               h_q;
  logic [NBW-1:0]              nb_q;
  logic [NHW-1:0]              nbh_q;
  logic [grr_pkg::FBYTE_W-1:0] wbyte_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_draw) begin
      code_q <= in_ch.char_code;
      px_q   <= in_ch.pos_x;
      py_q   <= in_ch.pos_y;
      w_q    <= w_eff;
      h_q    <= h_eff;
      nb_q   <= nb_eff;
      nbh_q  <= NHW'(nb_eff) * NHW'(h_eff);
    end
    if (cmd_i.latch_load) begin
      wbyte_q <= in_ch.font_byte;
    end
  end

  // Address register: load address or base product, modulo reduction, then byte walk with wrap
  logic [RW-1:0] red_q, red_d;
  logic [RW:0]   sub_q, sub_d;
  logic [PW-1:0] prod;
  logic          red_ge;

  assign prod   = PW'(code_q) * PW'(nbh_q);
  assign red_ge = {1'b0, red_q} >= sub_q;

  always_comb begin
    red_d = red_q;
    sub_d = sub_q;
    priority if (cmd_i.latch_load) begin
      red_d = RW'(in_ch.font_addr);
      sub_d = SUB_INIT;
    end else if (cmd_i.mul) begin
      red_d = RW'(prod);
      sub_d = SUB_INIT;
    end else if (cmd_i.red_step) begin
      if (red_ge) begin
        red_d = red_q - sub_q[RW-1:0];
      end
      sub_d = sub_q >> 1;
    end else if (cmd_i.acc) begin
      red_d = (red_q == ADDR_TOP) ? '0 : red_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_d;
    sub_q <= sub_d;
  end

  // Font store
  logic [7:0] rdata;

  grr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (red_q[AW-1:0]),
    .wdata_i (wbyte_q),
    .re_i    (cmd_i.ram_re),
    .raddr_i (red_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Byte and row counters, row accumulator
  logic [BCW-1:0]  bidx_q, bidx_d;
  logic [RCW-1:0]  row_q, row_d;
  logic [ACCW-1:0] acc_q, acc_d;
  logic            byte_last, row_last;

  assign byte_last = ((NBW + 1)'(bidx_q) + 1'b1) == (NBW + 1)'(nb_q);
  assign row_last  = ((HW + 1)'(row_q) + 1'b1) == (HW + 1)'(h_q);

  always_comb begin
    bidx_d = bidx_q;
    row_d  = row_q;
    acc_d  = acc_q;
    priority if (cmd_i.latch_draw) begin
      bidx_d = '0;
      row_d  = '0;
      acc_d  = '0;
    end else if (cmd_i.acc) begin
      acc_d[{bidx_q, 3'b000} +: 8] = rdata;
      bidx_d = byte_last ? '0 : bidx_q + 1'b1;
    end else if (cmd_i.emit_row) begin
      acc_d = '0;
      row_d = row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    bidx_q <= bidx_d;
    row_q  <= row_d;
    acc_q  <= acc_d;
  end

  // Dirty vertical range
  logic [grr_pkg::DIRTY_W-1:0] top_q, top_d, bot_q, bot_d, lo, hi;

  assign lo = grr_pkg::DIRTY_W'(in_ch.pos_y);
  assign hi = grr_pkg::DIRTY_W'(in_ch.pos_y) + grr_pkg::DIRTY_W'(h_eff);

  always_comb begin
    top_d = top_q;
    bot_d = bot_q;
    priority if (cmd_i.clear_dirty) begin
      top_d = '0;
      bot_d = '0;
    end else if (cmd_i.latch_draw) begin
      if (top_q == bot_q) begin
        top_d = lo;
        bot_d = hi;
      end else begin
        if (lo < top_q) top_d = lo;
        if (hi > bot_q) bot_d = hi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      bot_q <= '0;
    end else begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

  // Row payload: glyph row or underline cursor
  logic [ACCW+15:0]             acc_ext;
  logic [grr_pkg::BITS_W-1:0]   cur_bits;
  logic [5:0]                   pc_row6, pc_cur6;
  logic                         emit;

  assign acc_ext = (ACCW + 16)'(acc_q);
  assign pc_row6 = 6'(nb_q) << 3;
  assign pc_cur6 = 6'(w_q);
  assign emit    = cmd_i.emit_row | cmd_i.emit_cursor;

  always_comb begin
    for (int i = 0; i < grr_pkg::BITS_W; i++) begin
      cur_bits[i] = 6'(i) < pc_cur6;
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ch.row_x       <= px_q;
      out_ch.color_on    <= cfg_i.ink_color;
      out_ch.color_off   <= cfg_i.paper_color;
      out_ch.dirty_first <= top_q;
      out_ch.dirty_past  <= bot_q;
      if (cmd_i.emit_cursor) begin
        out_ch.row_y       <= grr_pkg::ROWY_W'(py_q) + grr_pkg::ROWY_W'(h_q) - 1'b1;
        out_ch.pixel_bits  <= cur_bits;
        out_ch.pixel_count <= pc_cur6[grr_pkg::CNT_W-1:0];
        out_ch.last        <= 1'b1;
      end else begin
        out_ch.row_y       <= grr_pkg::ROWY_W'(py_q) + grr_pkg::ROWY_W'(row_q);
        out_ch.pixel_bits  <= acc_ext[grr_pkg::BITS_W-1:0];
        out_ch.pixel_count <= pc_row6[grr_pkg::CNT_W-1:0];
        out_ch.last        <= row_last;
      end
    end
  end

  assign out_ch.valid = out_valid_q;
  assign in_ch.ready  = cmd_i.in_ready;

  // Status to the controller
  always_comb begin
    sts_o           = '0;
    sts_o.in_valid  = in_ch.valid;
    sts_o.in_cmd    = in_ch.command;
    sts_o.in_cursor = in_ch.single_char & (in_ch.char_code == grr_pkg::CURSOR_CODE);
    sts_o.red_done  = sub_q == SUB_LAST;
    sts_o.byte_last = byte_last;
    sts_o.row_last  = row_last;
    sts_o.out_free  = ~out_valid_q | out_ch.ready;
  end

`ifndef SYNTHESIS
  // A row is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_row || cmd_i.emit_cursor) |-> (!out_valid_q || out_ch.ready))
    else $error("row emitted over an untaken result");

  // Font reads and writes use a fully reduced address
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ram_re || cmd_i.ram_we) |-> ({1'b0, red_q} < (RW + 1)'(FONT_BYTES)))
    else $error("font address not reduced");

  // Reads never run past the glyph's last row
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ram_re |-> ((HW + 1)'(row_q) < (HW + 1)'(h_q)))
    else $error("row counter past glyph height");

  // The dirty range never turns inside out
  a_dirty_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= bot_q)
    else $error("dirty top below dirty bottom");
`endif

endmodule
